>>> src/hrm_pkg.sv
// Shared types and constants of the hue rotation matrix generator.
package hrm_pkg;

  localparam int unsigned ANGLE_FIELD_W = 16;
  localparam int unsigned OPACITY_W     = 8;
  localparam int unsigned COEF_W        = 16;
  localparam int unsigned Q30_SHIFT     = 30;

  localparam logic [30:0]        Q30_ONE    = 31'h4000_0000;
  localparam logic [30:0]        HALFPI_Q30 = 31'd1686629713;
  localparam logic signed [31:0] SQRT3_Q30  = 32'sd1859775393;

  localparam int unsigned SIN_STEPS   = 5;
  localparam int unsigned COS_STEPS   = 6;
  localparam int unsigned STEP_STAGES = 3;
  localparam int unsigned SIN_DIV [SIN_STEPS] = '{110, 72, 42, 20, 6};
  localparam int unsigned COS_DIV [COS_STEPS] = '{132, 90, 56, 30, 12, 2};
  localparam int unsigned SIDE_DEPTH  = COS_STEPS * STEP_STAGES;
  localparam int unsigned SIN_WAIT    = (COS_STEPS - SIN_STEPS) * STEP_STAGES;

  localparam logic [1:0] QUAD_I   = 2'd0;
  localparam logic [1:0] QUAD_II  = 2'd1;
  localparam logic [1:0] QUAD_III = 2'd2;
  localparam logic [1:0] QUAD_IV  = 2'd3;

  // Three times a matrix coefficient in Q30, and its three distinct values.
  localparam int unsigned V3_W      = 34;
  localparam int unsigned NUM_VALS  = 3;
  localparam int unsigned VAL_DIAG  = 0;
  localparam int unsigned VAL_PLUS  = 1;
  localparam int unsigned VAL_MINUS = 2;
  localparam logic signed [V3_W-1:0] V3_ONE = 34'sh0_4000_0000;

  // Opacity scaling divides by 3 * 255 in addition to the Q30 shift.
  localparam int unsigned SCALE_DIV    = 765;
  localparam int unsigned COEF_POS_MAX = 32767;
  localparam int unsigned COEF_NEG_MAX = 32768;

  typedef logic [30:0] q30_t;

  typedef struct packed {
    logic [30:0]          x;
    logic [31:0]          x2;
    logic [1:0]           quad;
    logic [OPACITY_W-1:0] opacity;
  } hrm_side_t;

  typedef struct packed {
    logic                                valid;
    logic [OPACITY_W-1:0]                opacity;
    logic [NUM_VALS-1:0][V3_W-1:0]       v3;
  } hrm_mtx_t;

  typedef struct packed {
    logic                                valid;
    logic [NUM_VALS-1:0][COEF_W-1:0]     coef;
  } hrm_coef_t;

endpackage

>>> src/hrm_in_if.sv
// Request channel: hue angle and opacity with a valid/ready handshake.
interface hrm_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] hue_angle;
  logic [7:0]  opacity;

  modport source (output valid, output hue_angle, output opacity, input ready);
  modport sink (input valid, input hue_angle, input opacity, output ready);
endinterface

>>> src/hrm_out_if.sv
// Result channel: nine signed Q2.14 matrix coefficients with a valid/ready handshake.
interface hrm_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] coef_r0_c0;
  logic signed [15:0] coef_r0_c1;
  logic signed [15:0] coef_r0_c2;
  logic signed [15:0] coef_r1_c0;
  logic signed [15:0] coef_r1_c1;
  logic signed [15:0] coef_r1_c2;
  logic signed [15:0] coef_r2_c0;
  logic signed [15:0] coef_r2_c1;
  logic signed [15:0] coef_r2_c2;

  modport source (
    output valid, output coef_r0_c0, output coef_r0_c1, output coef_r0_c2,
    output coef_r1_c0, output coef_r1_c1, output coef_r1_c2,
    output coef_r2_c0, output coef_r2_c1, output coef_r2_c2, input ready
  );
  modport sink (
    input valid, input coef_r0_c0, input coef_r0_c1, input coef_r0_c2,
    input coef_r1_c0, input coef_r1_c1, input coef_r1_c2,
    input coef_r2_c0, input coef_r2_c1, input coef_r2_c2, output ready
  );
endinterface

>>> src/hue_rotation_matrix_generator_core.sv
// Hue rotation color matrix generator: one request of hue angle and opacity gives the nine
// coefficients of a 3x3 matrix that turns colors about the grey axis, scaled by opacity/255.
// The block is a fixed 29-stage pipeline: it takes one transfer per cycle unless the output
// holds a result. The depth comes from the six Horner steps of the cosine series (three stages
// each, with the five sine steps running beside them), two front stages for the angle and
// its square, four stages for the matrix terms and five for opacity scaling with rounding
// and saturation. When a result is held at the output, the whole pipeline holds with it and
// input ready falls; nothing is dropped or repeated.
module hue_rotation_matrix_generator_core import hrm_pkg::*; #(
  parameter int unsigned ANGLE_BITS     = 16,
  parameter int unsigned COEF_FRAC_BITS = 14
) (
  input  logic clk_i,
  input  logic rst_ni,
  hrm_in_if.sink    in_i,
  hrm_out_if.source out_o
);

  logic            en;
  logic            front_valid;
  hrm_side_t       front_side;
  logic [SIDE_DEPTH:1] side_valid_q;
  hrm_side_t       side_q [1:SIDE_DEPTH];
  hrm_side_t       side_tap [SIDE_DEPTH+1];
  q30_t            t_cos [COS_STEPS+1];
  q30_t            t_sin [SIN_STEPS+1];
  q30_t            ts_q [SIN_WAIT];
  hrm_mtx_t        mtx;
  hrm_coef_t       coef;

  assign en         = !coef.valid || out_o.ready;
  assign in_i.ready = en;

  hrm_front #(
    .ANGLE_BITS (ANGLE_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .valid_i     (in_i.valid),
    .hue_angle_i (in_i.hue_angle),
    .opacity_i   (in_i.opacity),
    .valid_o     (front_valid),
    .side_o      (front_side)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side_valid_q <= '0;
    end else if (en) begin
      side_valid_q <= {side_valid_q[SIDE_DEPTH-1:1], front_valid};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      side_q[1] <= front_side;
      for (int k = 2; k <= SIDE_DEPTH; k++) begin
        side_q[k] <= side_q[k-1];
      end
      ts_q[0] <= t_sin[SIN_STEPS];
      for (int k = 1; k < SIN_WAIT; k++) begin
        ts_q[k] <= ts_q[k-1];
      end
    end
  end

  always_comb begin
    side_tap[0] = front_side;
    for (int k = 1; k <= SIDE_DEPTH; k++) begin
      side_tap[k] = side_q[k];
    end
  end

  assign t_cos[0] = Q30_ONE;
  assign t_sin[0] = Q30_ONE;

  for (genvar gi = 0; gi < COS_STEPS; gi++) begin : g_cos
    hrm_step #(
      .DIV (COS_DIV[gi])
    ) u_step (
      .clk_i (clk_i),
      .en_i  (en),
      .x2_i  (side_tap[gi*STEP_STAGES].x2),
      .t_i   (t_cos[gi]),
      .t_o   (t_cos[gi+1])
    );
  end

  for (genvar gi = 0; gi < SIN_STEPS; gi++) begin : g_sin
    hrm_step #(
      .DIV (SIN_DIV[gi])
    ) u_step (
      .clk_i (clk_i),
      .en_i  (en),
      .x2_i  (side_tap[gi*STEP_STAGES].x2),
      .t_i   (t_sin[gi]),
      .t_o   (t_sin[gi+1])
    );
  end

  hrm_matrix u_matrix (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (side_valid_q[SIDE_DEPTH]),
    .side_i  (side_q[SIDE_DEPTH]),
    .sin_t_i (ts_q[SIN_WAIT-1]),
    .cos_i   (t_cos[COS_STEPS]),
    .mtx_o   (mtx)
  );

  hrm_scale #(
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_scale (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .mtx_i  (mtx),
    .coef_o (coef)
  );

  assign out_o.valid      = coef.valid;
  assign out_o.coef_r0_c0 = $signed(coef.coef[VAL_DIAG]);
  assign out_o.coef_r0_c1 = $signed(coef.coef[VAL_PLUS]);
  assign out_o.coef_r0_c2 = $signed(coef.coef[VAL_MINUS]);
  assign out_o.coef_r1_c0 = $signed(coef.coef[VAL_MINUS]);
  assign out_o.coef_r1_c1 = $signed(coef.coef[VAL_DIAG]);
  assign out_o.coef_r1_c2 = $signed(coef.coef[VAL_PLUS]);
  assign out_o.coef_r2_c0 = $signed(coef.coef[VAL_PLUS]);
  assign out_o.coef_r2_c1 = $signed(coef.coef[VAL_MINUS]);
  assign out_o.coef_r2_c2 = $signed(coef.coef[VAL_DIAG]);

endmodule

>>> src/hrm_front.sv
// Front stages: angle to first-quadrant radians in Q30 and its square.
module hrm_front import hrm_pkg::*; #(
  parameter int unsigned ANGLE_BITS = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     en_i,
  input  logic                     valid_i,
  input  logic [ANGLE_FIELD_W-1:0] hue_angle_i,
  input  logic [OPACITY_W-1:0]     opacity_i,
  output logic                     valid_o,
  output hrm_side_t                side_o
);

  localparam int unsigned FRAC_W = ANGLE_BITS - 2;
  localparam int unsigned PROD_W = FRAC_W + 31;
  localparam int unsigned EXT_W  = ANGLE_BITS + ANGLE_FIELD_W;

  logic [EXT_W-1:0]      ang_ext;
  logic [ANGLE_BITS-1:0] ang;
  logic [PROD_W-1:0]     x_prod;
  logic [61:0]           xx_prod;

  logic [1:0]            valid_q;
  logic [30:0]           x1_q;
  logic [1:0]            quad1_q;
  logic [OPACITY_W-1:0]  op1_q;
  hrm_side_t             side_q;

  assign ang_ext = {{ANGLE_BITS{1'b0}}, hue_angle_i};
  assign ang     = ang_ext[ANGLE_BITS-1:0];
  assign x_prod  = PROD_W'(ang[FRAC_W-1:0]) * PROD_W'(HALFPI_Q30);
  assign xx_prod = 62'(x1_q) * 62'(x1_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en_i) begin
      valid_q <= {valid_q[0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x1_q           <= x_prod[PROD_W-1:FRAC_W];
      quad1_q        <= ang[ANGLE_BITS-1:ANGLE_BITS-2];
      op1_q          <= opacity_i;
      side_q.x       <= x1_q;
      side_q.x2      <= xx_prod[61:30];
      side_q.quad    <= quad1_q;
      side_q.opacity <= op1_q;
    end
  end

  assign valid_o = valid_q[1];
  assign side_o  = side_q;

endmodule

>>> src/hrm_step.sv
// One Horner step t' = 1 - floor(x2*t)/DIV in Q30, clamped at zero, over three stages.
module hrm_step import hrm_pkg::*; #(
  parameter int unsigned DIV = 2
) (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [31:0] x2_i,
  input  q30_t        t_i,
  output q30_t        t_o
);

  // Reciprocal below 2^32; the estimate is low by at most one.
  localparam int unsigned SHIFT      = 31 + $clog2(DIV);
  localparam logic [63:0] RECIP_FULL = (64'd1 << SHIFT) / 64'(DIV);
  localparam logic [31:0] RECIP      = RECIP_FULL[31:0];
  localparam logic [31:0] DIV_W      = 32'(DIV);

  logic [62:0]        p_prod;
  logic [31:0]        p_q;
  logic [31:0]        p2_q;
  logic [63:0]        pm_q;
  logic [31:0]        quo;
  logic [31:0]        rem;
  logic [31:0]        quo_c;
  logic signed [32:0] diff;
  q30_t               t_d;
  q30_t               t_q;

  assign p_prod = 63'(x2_i) * 63'(t_i);
  assign quo    = 32'(pm_q >> SHIFT);
  assign rem    = p2_q - quo * DIV_W;
  assign quo_c  = quo + {31'd0, (rem >= DIV_W)};
  assign diff   = $signed({2'b00, Q30_ONE}) - $signed({1'b0, quo_c});
  assign t_d    = diff[32] ? '0 : diff[30:0];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q  <= p_prod[61:30];
      pm_q <= 64'(p_q) * 64'(RECIP);
      p2_q <= p_q;
      t_q  <= t_d;
    end
  end

  assign t_o = t_q;

endmodule

>>> src/hrm_matrix.sv
// Matrix stages: sine, quadrant mapping, sqrt(3) term and the three distinct coefficients.
module hrm_matrix import hrm_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      en_i,
  input  logic      valid_i,
  input  hrm_side_t side_i,
  input  q30_t      sin_t_i,
  input  q30_t      cos_i,
  output hrm_mtx_t  mtx_o
);

  localparam logic signed [63:0] RND_BIAS = 64'sd1073741823;

  logic [61:0]                    sn_prod;
  logic signed [31:0]             sn_s;
  logic signed [31:0]             cs_s;
  logic signed [31:0]             s_val;
  logic signed [31:0]             c_val;
  logic signed [63:0]             rnd;
  logic signed [V3_W-1:0]         c_ext;

  logic [3:0]                     valid_q;
  logic [31:0]                    sn1_q;
  q30_t                           cs1_q;
  logic [1:0]                     quad1_q;
  logic [OPACITY_W-1:0]           op1_q;
  logic signed [63:0]             rp2_q;
  logic signed [31:0]             c2_q;
  logic [OPACITY_W-1:0]           op2_q;
  logic signed [V3_W-1:0]         r3_q;
  logic signed [V3_W-1:0]         diag3_q;
  logic signed [V3_W-1:0]         base3_q;
  logic [OPACITY_W-1:0]           op3_q;
  logic [NUM_VALS-1:0][V3_W-1:0]  v3_q;
  logic [OPACITY_W-1:0]           op4_q;

  assign sn_prod = 62'(side_i.x) * 62'(sin_t_i);
  assign sn_s    = $signed(sn1_q);
  assign cs_s    = $signed({1'b0, cs1_q});

  always_comb begin
    unique case (quad1_q)
      QUAD_I: begin
        s_val = sn_s;
        c_val = cs_s;
      end
      QUAD_II: begin
        s_val = cs_s;
        c_val = -sn_s;
      end
      QUAD_III: begin
        s_val = -sn_s;
        c_val = -cs_s;
      end
      QUAD_IV: begin
        s_val = -cs_s;
        c_val = sn_s;
      end
      default: begin
        s_val = sn_s;
        c_val = cs_s;
      end
    endcase
  end

  // The sqrt(3) term truncates toward zero.
  assign rnd   = rp2_q + (rp2_q[63] ? RND_BIAS : 64'sd0);
  assign c_ext = V3_W'(c2_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en_i) begin
      valid_q <= {valid_q[2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sn1_q   <= sn_prod[61:30];
      cs1_q   <= cos_i;
      quad1_q <= side_i.quad;
      op1_q   <= side_i.opacity;

      rp2_q   <= 64'(s_val) * 64'(SQRT3_Q30);
      c2_q    <= c_val;
      op2_q   <= op1_q;

      r3_q    <= $signed(rnd[63:30]);
      diag3_q <= V3_ONE + (c_ext <<< 1);
      base3_q <= V3_ONE - c_ext;
      op3_q   <= op2_q;

      v3_q[VAL_DIAG]  <= diag3_q;
      v3_q[VAL_PLUS]  <= base3_q + r3_q;
      v3_q[VAL_MINUS] <= base3_q - r3_q;
      op4_q           <= op3_q;
    end
  end

  always_comb begin
    mtx_o.valid   = valid_q[3];
    mtx_o.opacity = op4_q;
    mtx_o.v3      = v3_q;
  end

endmodule

>>> src/hrm_scale.sv
// Scaling stages: multiply by opacity, round the division by 765 * 2^(30-F), saturate.
module hrm_scale import hrm_pkg::*; #(
  parameter int unsigned COEF_FRAC_BITS = 14
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      en_i,
  input  hrm_mtx_t  mtx_i,
  output hrm_coef_t coef_o
);

  localparam int unsigned MAG_W       = V3_W - 1;
  localparam int unsigned PROD_W      = MAG_W + OPACITY_W;
  localparam int unsigned SUM_W       = PROD_W + 1;
  localparam int unsigned SH          = Q30_SHIFT - COEF_FRAC_BITS;
  localparam int unsigned NW          = SUM_W - SH;
  localparam int unsigned MUL_W       = 2 * NW;
  localparam int unsigned RECIP_SHIFT = NW + $clog2(SCALE_DIV) - 1;
  localparam logic [63:0] RECIP_FULL  = (64'd1 << RECIP_SHIFT) / 64'(SCALE_DIV);
  localparam logic [NW-1:0] RECIP     = RECIP_FULL[NW-1:0];
  localparam logic [NW-1:0] DIV_N     = NW'(SCALE_DIV);
  localparam logic [NW-1:0] POS_MAX_N = NW'(COEF_POS_MAX);
  localparam logic [NW-1:0] NEG_MAX_N = NW'(COEF_NEG_MAX);
  localparam logic [SUM_W-1:0] HALF_DEN = SUM_W'(SCALE_DIV) << (SH - 1);

  logic [4:0]                      valid_q;
  logic [NUM_VALS-1:0]             neg1_q;
  logic [NUM_VALS-1:0]             neg2_q;
  logic [NUM_VALS-1:0]             neg3_q;
  logic [NUM_VALS-1:0]             neg4_q;
  logic [OPACITY_W-1:0]            op1_q;
  logic [NUM_VALS-1:0][MAG_W-1:0]  mag1_q;
  logic [NUM_VALS-1:0][PROD_W-1:0] prod2_q;
  logic [NUM_VALS-1:0][NW-1:0]     n3_q;
  logic [NUM_VALS-1:0][NW-1:0]     n4_q;
  logic [NUM_VALS-1:0][MUL_W-1:0]  nm4_q;
  logic [NUM_VALS-1:0][COEF_W-1:0] coef_q;

  logic [NUM_VALS-1:0][MAG_W-1:0]  mag_d;
  logic [NUM_VALS-1:0][SUM_W-1:0]  sum_d;
  logic [NUM_VALS-1:0][NW-1:0]     quo_d;
  logic [NUM_VALS-1:0][NW-1:0]     rem_d;
  logic [NUM_VALS-1:0][NW-1:0]     quo_c_d;
  logic [NUM_VALS-1:0][NW-1:0]     quo_n_d;
  logic [NUM_VALS-1:0][COEF_W-1:0] coef_d;

  always_comb begin
    for (int l = 0; l < NUM_VALS; l++) begin
      mag_d[l]   = mtx_i.v3[l][V3_W-1] ? MAG_W'(-$signed(mtx_i.v3[l]))
                                        : mtx_i.v3[l][MAG_W-1:0];
      sum_d[l]   = SUM_W'(prod2_q[l]) + HALF_DEN;
      quo_d[l]   = NW'(nm4_q[l] >> RECIP_SHIFT);
      rem_d[l]   = n4_q[l] - quo_d[l] * DIV_N;
      quo_c_d[l] = quo_d[l] + NW'(rem_d[l] >= DIV_N);
      quo_n_d[l] = ~quo_c_d[l] + NW'(1);
      if (neg4_q[l]) begin
        coef_d[l] = (quo_c_d[l] > NEG_MAX_N) ? NEG_MAX_N[COEF_W-1:0]
                                             : quo_n_d[l][COEF_W-1:0];
      end else begin
        coef_d[l] = (quo_c_d[l] > POS_MAX_N) ? POS_MAX_N[COEF_W-1:0]
                                             : quo_c_d[l][COEF_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en_i) begin
      valid_q <= {valid_q[3:0], mtx_i.valid};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      op1_q <= mtx_i.opacity;
      for (int l = 0; l < NUM_VALS; l++) begin
        neg1_q[l]  <= mtx_i.v3[l][V3_W-1];
        mag1_q[l]  <= mag_d[l];
        neg2_q[l]  <= neg1_q[l];
        prod2_q[l] <= PROD_W'(mag1_q[l]) * PROD_W'(op1_q);
        neg3_q[l]  <= neg2_q[l];
        n3_q[l]    <= sum_d[l][SUM_W-1:SH];
        neg4_q[l]  <= neg3_q[l];
        n4_q[l]    <= n3_q[l];
        nm4_q[l]   <= MUL_W'(n3_q[l]) * MUL_W'(RECIP);
        coef_q[l]  <= coef_d[l];
      end
    end
  end

  always_comb begin
    coef_o.valid = valid_q[4];
    coef_o.coef  = coef_q;
  end

endmodule
